// ----- design/att_pkg.sv -----
// Package for the acknowledgement timeout tracker: widths, codes and the
// command and status words between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package att_pkg;

   // Tracker sizing
   localparam int ENTRY_COUNT = 16;
   localparam int IDX_W       = $clog2(ENTRY_COUNT);
   localparam int FILL_W      = $clog2(ENTRY_COUNT + 1);
   localparam int SUM_W       = FILL_W + 1;

   // Field widths
   localparam int MODE_W = 2;
   localparam int ID_W   = 4;
   localparam int TIME_W = 32;
   localparam int TMO_W  = 16;
   localparam int CNT_W  = 32;

   // Results per poll
   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd100;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_SEND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ACK  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_POLL = 2'd2;

   // Event codes
   localparam logic EVENT_OK      = 1'b0;
   localparam logic EVENT_TIMEOUT = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic send;
      logic ack;
      logic poll_init;
      logic fifo_rd;
      logic time_rd;
      logic pop_free;
      logic pop_timeout;
      logic flush;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              fifo_empty;
      logic              head_live;
      logic              head_young;
      logic              cap_hit;
   } status_type;

endpackage

// ----- design/att_datapath.sv -----
// Datapath of the acknowledgement timeout tracker: entry stamps, wait FIFO,
// totals, pending result word and result registers.
// Depends on att_pkg.
`timescale 1ns / 1ps

module att_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  att_pkg::cmd_type              cmd,
   output att_pkg::status_type           status,
   input  logic [att_pkg::MODE_W-1:0]    req_mode,
   input  logic [att_pkg::ID_W-1:0]      req_entry_id,
   input  logic [att_pkg::TIME_W-1:0]    req_now_ms,
   input  logic                          csr_wr_en,
   input  logic [att_pkg::TMO_W-1:0]     csr_wr_data,
   output logic                          rsp_valid,
   output logic                          rsp_event_res,
   output logic [att_pkg::ID_W-1:0]      rsp_event_id,
   output logic                          rsp_last,
   output logic [att_pkg::CNT_W-1:0]     rsp_timeout_count,
   output logic [att_pkg::CNT_W-1:0]     rsp_handled_count
);

   // Captured request word
   logic [att_pkg::MODE_W-1:0] mode_ff;
   logic [att_pkg::ID_W-1:0]   id_ff;
   logic [att_pkg::TIME_W-1:0] now_ff;

   logic [att_pkg::TMO_W-1:0]  timeout_ff;

   // Entry stamps with per-entry live bits
   logic [att_pkg::TIME_W-1:0]      time_mem [att_pkg::ENTRY_COUNT];
   logic [att_pkg::ENTRY_COUNT-1:0] valid_ff, valid_in;
   logic [att_pkg::TIME_W-1:0]      stamp_ff;

   // Wait FIFO
   logic [att_pkg::ID_W-1:0]   fifo_mem [att_pkg::ENTRY_COUNT];
   logic [att_pkg::IDX_W-1:0]  head_ff, head_in;
   logic [att_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [att_pkg::ID_W-1:0]   hid_ff;

   // Totals and poll bookkeeping
   logic [att_pkg::CNT_W-1:0]     tout_total_ff, tout_total_in;
   logic [att_pkg::CNT_W-1:0]     hand_total_ff, hand_total_in;
   logic [att_pkg::RES_CNT_W-1:0] res_n_ff, res_n_in;

   // Pending timeout word, held until the next one shows whether it is last
   logic                      pend_valid_ff, pend_valid_in;
   logic [att_pkg::ID_W-1:0]  pend_id_ff, pend_id_in;
   logic [att_pkg::CNT_W-1:0] pend_tcnt_ff, pend_tcnt_in;
   logic [att_pkg::CNT_W-1:0] pend_hcnt_ff, pend_hcnt_in;

   // Result registers
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_res_ff, rsp_res_in;
   logic [att_pkg::ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [att_pkg::CNT_W-1:0] rsp_tcnt_ff, rsp_tcnt_in;
   logic [att_pkg::CNT_W-1:0] rsp_hcnt_ff, rsp_hcnt_in;

   logic                       id_ok;
   logic [att_pkg::IDX_W-1:0]  idx;
   logic [att_pkg::IDX_W-1:0]  hidx;
   logic [att_pkg::TIME_W-1:0] stamp_new;
   logic [att_pkg::SUM_W-1:0]  tail_sum;
   logic [att_pkg::IDX_W-1:0]  tail;
   logic                       fifo_full;
   logic [att_pkg::IDX_W-1:0]  head_next;
   logic [att_pkg::TIME_W-1:0] age;
   logic                       head_live;
   logic                       head_young;
   logic                       cap_hit;

   // Capture the request word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         id_ff   <= req_entry_id;
         now_ff  <= req_now_ms;
      end
   end

   // Timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= att_pkg::TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   // Address and compare logic
   assign id_ok     = 32'(id_ff) < 32'(att_pkg::ENTRY_COUNT);
   assign idx       = att_pkg::IDX_W'(id_ff);
   assign hidx      = att_pkg::IDX_W'(hid_ff);
   assign stamp_new = (now_ff == '0) ? att_pkg::TIME_W'(1) : now_ff;
   assign tail_sum  = att_pkg::SUM_W'(head_ff) + att_pkg::SUM_W'(fill_ff);
   assign tail      = (tail_sum >= att_pkg::SUM_W'(att_pkg::ENTRY_COUNT))
                      ? att_pkg::IDX_W'(tail_sum - att_pkg::SUM_W'(att_pkg::ENTRY_COUNT))
                      : att_pkg::IDX_W'(tail_sum);
   assign fifo_full = fill_ff == att_pkg::FILL_W'(att_pkg::ENTRY_COUNT);
   assign head_next = (head_ff == att_pkg::IDX_W'(att_pkg::ENTRY_COUNT - 1))
                      ? '0 : head_ff + att_pkg::IDX_W'(1);
   assign age        = now_ff - stamp_ff;
   assign head_live  = valid_ff[hidx];
   assign head_young = age < att_pkg::TIME_W'(timeout_ff);
   assign cap_hit    = res_n_ff == att_pkg::RES_CNT_W'(att_pkg::MAX_RESULTS);

   always_comb begin
      status.mode       = mode_ff;
      status.fifo_empty = fill_ff == '0;
      status.head_live  = head_live;
      status.head_young = head_young;
      status.cap_hit    = cap_hit;
   end

   // Stamp memory: write on send, read the head's stamp
   always_ff @(posedge clock) begin
      if (cmd.send && id_ok) begin
         time_mem[idx] <= stamp_new;
      end
      if (cmd.time_rd) begin
         stamp_ff <= time_mem[hidx];
      end
   end

   // FIFO memory: push on send, read the head
   always_ff @(posedge clock) begin
      if (cmd.send && id_ok && !fifo_full) begin
         fifo_mem[tail] <= id_ff;
      end
      if (cmd.fifo_rd) begin
         hid_ff <= fifo_mem[head_ff];
      end
   end

   // Next-state logic for bookkeeping and results
   always_comb begin
      valid_in      = valid_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      tout_total_in = tout_total_ff;
      hand_total_in = hand_total_ff;
      res_n_in      = res_n_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_tcnt_in  = pend_tcnt_ff;
      pend_hcnt_in  = pend_hcnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_res_in    = rsp_res_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_tcnt_in   = rsp_tcnt_ff;
      rsp_hcnt_in   = rsp_hcnt_ff;

      // Send: mark live, queue if room
      if (cmd.send && id_ok) begin
         valid_in[idx] = 1'b1;
         if (!fifo_full) begin
            fill_in = fill_ff + att_pkg::FILL_W'(1);
         end
      end

      // Ack of a live entry: free it and report
      if (cmd.ack && id_ok && valid_ff[idx]) begin
         valid_in[idx] = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_res_in    = att_pkg::EVENT_OK;
         rsp_id_in     = id_ff;
         rsp_last_in   = 1'b1;
         rsp_tcnt_in   = tout_total_ff;
         rsp_hcnt_in   = hand_total_ff;
      end

      if (cmd.poll_init) begin
         res_n_in      = '0;
         pend_valid_in = 1'b0;
      end

      // Drop a free head
      if (cmd.pop_free) begin
         hand_total_in = hand_total_ff + att_pkg::CNT_W'(1);
         head_in       = head_next;
         fill_in       = fill_ff - att_pkg::FILL_W'(1);
      end

      // Retire a timed-out head: release the previous word, hold this one
      if (cmd.pop_timeout) begin
         tout_total_in = tout_total_ff + att_pkg::CNT_W'(1);
         hand_total_in = hand_total_ff + att_pkg::CNT_W'(1);
         head_in       = head_next;
         fill_in       = fill_ff - att_pkg::FILL_W'(1);
         res_n_in      = res_n_ff + att_pkg::RES_CNT_W'(1);
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_res_in   = att_pkg::EVENT_TIMEOUT;
            rsp_id_in    = pend_id_ff;
            rsp_last_in  = 1'b0;
            rsp_tcnt_in  = pend_tcnt_ff;
            rsp_hcnt_in  = pend_hcnt_ff;
         end
         pend_valid_in = 1'b1;
         pend_id_in    = hid_ff;
         pend_tcnt_in  = tout_total_in;
         pend_hcnt_in  = hand_total_in;
      end

      // End of poll: release the held word as the last one
      if (cmd.flush && pend_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_res_in    = att_pkg::EVENT_TIMEOUT;
         rsp_id_in     = pend_id_ff;
         rsp_last_in   = 1'b1;
         rsp_tcnt_in   = pend_tcnt_ff;
         rsp_hcnt_in   = pend_hcnt_ff;
         pend_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         head_ff       <= '0;
         fill_ff       <= '0;
         tout_total_ff <= '0;
         hand_total_ff <= '0;
         res_n_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         tout_total_ff <= tout_total_in;
         hand_total_ff <= hand_total_in;
         res_n_ff      <= res_n_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_id_ff   <= pend_id_in;
      pend_tcnt_ff <= pend_tcnt_in;
      pend_hcnt_ff <= pend_hcnt_in;
      rsp_res_ff   <= rsp_res_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_tcnt_ff  <= rsp_tcnt_in;
      rsp_hcnt_ff  <= rsp_hcnt_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_res     = rsp_res_ff;
   assign rsp_event_id      = rsp_id_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_timeout_count = rsp_tcnt_ff;
   assign rsp_handled_count = rsp_hcnt_ff;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= att_pkg::ENTRY_COUNT)
      else $error("wait FIFO fill beyond its depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.fifo_rd || cmd.pop_free || cmd.pop_timeout) |-> fill_ff != '0)
      else $error("FIFO read or pop while empty");

   a_timeout_cause: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_timeout |-> (head_live && !head_young && !cap_hit))
      else $error("timeout retired without cause");

   a_ok_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_res_ff == att_pkg::EVENT_OK) |-> rsp_last_ff)
      else $error("ok word not marked last");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> pend_valid_ff)
      else $error("non-last word with nothing held behind it");

endmodule

// ----- design/att_ctrl.sv -----
// Controller of the acknowledgement timeout tracker: sequences request
// decode and the poll walk over the wait FIFO.
// Depends on att_pkg.
`timescale 1ns / 1ps

module att_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output att_pkg::cmd_type    cmd,
   input  att_pkg::status_type status
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_HEAD   = 3'd3;
   localparam logic [2:0] ST_EVAL   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;

   assign busy = state_ff != ST_IDLE;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.mode)
               att_pkg::MODE_SEND: begin
                  cmd.send = 1'b1;
                  state_in = ST_IDLE;
               end
               att_pkg::MODE_ACK: begin
                  cmd.ack  = 1'b1;
                  state_in = ST_IDLE;
               end
               att_pkg::MODE_POLL: begin
                  cmd.poll_init = 1'b1;
                  state_in      = ST_CHECK;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_CHECK: begin
            if (status.fifo_empty) begin
               state_in = ST_FINISH;
            end else begin
               cmd.fifo_rd = 1'b1;
               state_in    = ST_HEAD;
            end
         end
         ST_HEAD: begin
            cmd.time_rd = 1'b1;
            state_in    = ST_EVAL;
         end
         ST_EVAL: begin
            if (!status.head_live) begin
               cmd.pop_free = 1'b1;
               state_in     = ST_CHECK;
            end else if (status.head_young || status.cap_hit) begin
               state_in = ST_FINISH;
            end else begin
               cmd.pop_timeout = 1'b1;
               state_in        = ST_CHECK;
            end
         end
         ST_FINISH: begin
            cmd.flush = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/ack_timeout_tracker.sv -----
// Top level of the acknowledgement timeout tracker.
// Joins att_ctrl and att_datapath; depends on att_pkg.
//
// Use: raise start with req_mode, req_entry_id and req_now_ms; the word is
// taken at a clock edge where start is high and busy is low. Mode send stamps
// the entry and queues its id if the FIFO has room, mode ack frees a live
// entry and reports ok, mode poll retires FIFO heads: free heads are
// dropped, old ones reported as timeouts, stopping at a young live head or
// after sixteen timeouts. Results appear on the rsp_ ports for one cycle
// each, marked by rsp_valid; rsp_last flags the final word of a request.
// There is no back-pressure. A send or ack holds busy through the decode
// state only; an ack result is registered in the decode state. A poll
// steps through check, head and eval for each head it examines (a FIFO
// read, a stamp read and a compare) and ends in finish, whether the walk
// empties the FIFO or a young head or the cap stops it.
// Each timeout word waits for the next timeout, the last one for finish.
// csr_wr_en writes timeout_ms (reset 100) from csr_wr_data; write only
// while busy is low. Reset frees all entries, empties the FIFO and clears
// both totals; no clearing pass is needed.
`timescale 1ns / 1ps

module ack_timeout_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [att_pkg::MODE_W-1:0]    req_mode,
   input  logic [att_pkg::ID_W-1:0]      req_entry_id,
   input  logic [att_pkg::TIME_W-1:0]    req_now_ms,
   input  logic                          csr_wr_en,
   input  logic [att_pkg::TMO_W-1:0]     csr_wr_data,
   output logic                          rsp_valid,
   output logic                          rsp_event_res,
   output logic [att_pkg::ID_W-1:0]      rsp_event_id,
   output logic                          rsp_last,
   output logic [att_pkg::CNT_W-1:0]     rsp_timeout_count,
   output logic [att_pkg::CNT_W-1:0]     rsp_handled_count
);

   att_pkg::cmd_type    cmd;
   att_pkg::status_type status;

   // Sequencer
   att_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // Storage and arithmetic
   att_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_mode),
      .req_entry_id      (req_entry_id),
      .req_now_ms        (req_now_ms),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_event_res     (rsp_event_res),
      .rsp_event_id      (rsp_event_id),
      .rsp_last          (rsp_last),
      .rsp_timeout_count (rsp_timeout_count),
      .rsp_handled_count (rsp_handled_count)
   );

endmodule
